// ===== hw/rtl/pes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projectile Euler step package
// Shared types and constants for the projectile step block.
// ----------------------------------------------------------------------------
package pes_pkg;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 48;

  localparam logic [CFG_IDX_BITS-1:0] REG_MAGNUS = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DRAG   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRAV   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TSTEP  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_TLIMIT = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_GROUND = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIND   = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPIN   = 3'd7;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // square root unit handshake
  typedef struct packed {
    logic start;
    logic [65:0] radicand;
  } pes_sqrt_req_t;

  typedef struct packed {
    logic busy;
    logic [32:0] root;
  } pes_sqrt_rsp_t;
endpackage

// ===== hw/rtl/pes_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer square root
// Bit-pair restoring square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pes_sqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pes_pkg::pes_sqrt_req_t req,
  output pes_pkg::pes_sqrt_rsp_t rsp
);
  logic [65:0] x_r, x_nxt;
  logic [65:0] r_r, r_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [65:0] b;
  logic [65:0] rb;

  assign b = 66'd1 << {cnt_r, 1'b0};
  assign rb = r_r + b;

  always_comb begin
    x_nxt = x_r;
    r_nxt = r_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      x_nxt = req.radicand;
      r_nxt = '0;
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (x_r >= rb) begin
        x_nxt = x_r - rb;
        r_nxt = (r_r >> 1) + b;
      end else begin
        r_nxt = r_r >> 1;
      end
      if (cnt_r == 6'd0) busy_nxt = 1'b0;
      else cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    x_r <= x_nxt;
    r_r <= r_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.root = r_r[32:0];
endmodule

// ===== hw/rtl/projectile_euler_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projectile Euler step
// Fixed-point 3-D flight with gravity, quadratic drag and Magnus lift.
// ----------------------------------------------------------------------------
// channel | direction | handshake        | payload
// in_     | input     | in_valid/stall   | action, start position, velocity
// out_    | output    | out_valid/stall  | position, velocity, elapsed, landed
// cfg_    | input     | cfg_we           | cfg_index, cfg_data
// A load, or a tick once landed, goes from IDLE through DONE to OUT, where
// the result is offered. On a flying projectile a tick runs through MUL,
// SQRT and MUL again: one shared 34x34 multiplier carries 19 products in
// sequence and the square root gives one bit a cycle. The next transaction
// is taken the cycle after the result is accepted. rst_n is synchronous;
// stalls on the output hold the result register.
// ----------------------------------------------------------------------------
module projectile_euler_step #(
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_action,
  input  logic signed [31:0]  in_start_pos_x,
  input  logic signed [31:0]  in_start_pos_y,
  input  logic signed [31:0]  in_start_pos_z,
  input  logic signed [31:0]  in_start_vel_x,
  input  logic signed [31:0]  in_start_vel_y,
  input  logic signed [31:0]  in_start_vel_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_pos_x,
  output logic signed [31:0]  out_pos_y,
  output logic signed [31:0]  out_pos_z,
  output logic signed [31:0]  out_vel_x,
  output logic signed [31:0]  out_vel_y,
  output logic signed [31:0]  out_vel_z,
  output logic [31:0]         out_elapsed,
  output logic                out_landed
);
  localparam int SB = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam logic signed [71:0] SMAX = (72'sd1 <<< (SB - 1)) - 72'sd1;
  localparam logic signed [71:0] SMIN = -SMAX - 72'sd1;
  localparam logic [32:0] TMAX = (33'd1 << SB) - 33'd1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [71:0] t;
    t = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
    return t[31:0];
  endfunction

  logic [31:0] magnus_r, drag_r, tlimit_r;
  logic signed [31:0] grav_r;
  logic [15:0] tstep_r;
  logic [30:0] ground_r;
  logic signed [15:0] wind_r [3];
  logic signed [15:0] spin_r [3];

  logic signed [31:0] pos_r [3];
  logic signed [31:0] vel_r [3];
  logic signed [31:0] rel_r [3];
  logic signed [71:0] acc_r [3];
  logic [65:0] sq_r;
  logic [32:0] time_r;
  logic [31:0] k_r;
  logic [2:0] state_r;
  logic [4:0] op_r;
  logic sq_go_r;

  // shared multiplier operands
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  assign prod = ma * mb;

  pes_pkg::pes_sqrt_req_t sreq;
  pes_pkg::pes_sqrt_rsp_t srsp;
  assign sreq.start = sq_go_r;
  assign sreq.radicand = sq_r;
  pes_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sreq), .rsp(srsp));

  logic flying;
  assign flying = (time_r < {1'b0, tlimit_r}) && (pos_r[1] > $signed({1'b0, ground_r}));

  // op plan: 0-2 squares, 3-8 cross terms, then sqrt, 9 k, 10-12 magnus,
  // 13-15 drag, 16 vel update, 17-19 position.
  logic [1:0] ci;
  always_comb begin
    ma = '0;
    mb = '0;
    ci = 2'd0;
    unique case (op_r)
      5'd0, 5'd1, 5'd2: begin
        ci = op_r[1:0];
        ma = 34'(rel_r[ci]); mb = 34'(rel_r[ci]);
      end
      5'd3: begin ma = 34'(spin_r[1]); mb = 34'(rel_r[2]); end
      5'd4: begin ma = 34'(spin_r[2]); mb = 34'(rel_r[1]); end
      5'd5: begin ma = 34'(spin_r[2]); mb = 34'(rel_r[0]); end
      5'd6: begin ma = 34'(spin_r[0]); mb = 34'(rel_r[2]); end
      5'd7: begin ma = 34'(spin_r[0]); mb = 34'(rel_r[1]); end
      5'd8: begin ma = 34'(spin_r[1]); mb = 34'(rel_r[0]); end
      5'd9: begin ma = $signed({2'd0, drag_r}); mb = $signed({1'b0, srsp.root}); end
      5'd10, 5'd11, 5'd12: begin
        ci = 2'(op_r - 5'd10);
        ma = 34'(sat32(acc_r[ci] >>> 8)); mb = $signed({2'd0, magnus_r});
      end
      5'd13, 5'd14, 5'd15: begin
        ci = 2'(op_r - 5'd13);
        ma = $signed({2'd0, k_r}); mb = 34'(rel_r[ci]);
      end
      5'd17, 5'd18, 5'd19: begin
        ci = 2'(op_r - 5'd17);
        ma = 34'(vel_r[ci]); mb = $signed({18'd0, tstep_r});
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  logic [43:0] kfull;
  assign kfull = prod[67:24];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r <= '0;
      sq_go_r <= 1'b0;
      magnus_r <= '0; drag_r <= '0; grav_r <= '0;
      tstep_r <= 16'd655; tlimit_r <= 32'd655360; ground_r <= '0;
      for (int i = 0; i < 3; i++) begin
        wind_r[i] <= '0; spin_r[i] <= '0; pos_r[i] <= '0; vel_r[i] <= '0;
      end
      time_r <= '0;
    end else begin
      sq_go_r <= (state_r == ST_MUL) && (op_r == 5'd8);
      if (cfg_we) begin
        unique case (cfg_index)
          pes_pkg::REG_MAGNUS: magnus_r <= cfg_data[31:0];
          pes_pkg::REG_DRAG:   drag_r <= cfg_data[31:0];
          pes_pkg::REG_GRAV:   grav_r <= cfg_data[31:0];
          pes_pkg::REG_TSTEP:  tstep_r <= cfg_data[15:0];
          pes_pkg::REG_TLIMIT: tlimit_r <= cfg_data[31:0];
          pes_pkg::REG_GROUND: ground_r <= cfg_data[30:0];
          pes_pkg::REG_WIND:
            for (int i = 0; i < 3; i++) wind_r[i] <= cfg_data[16*i +: 16];
          pes_pkg::REG_SPIN:
            for (int i = 0; i < 3; i++) spin_r[i] <= cfg_data[16*i +: 16];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: if (in_valid) begin
          if (in_action == pes_pkg::ACT_LOAD) begin
            pos_r[0] <= sat32(72'(in_start_pos_x));
            pos_r[1] <= sat32(72'(in_start_pos_y));
            pos_r[2] <= sat32(72'(in_start_pos_z));
            vel_r[0] <= sat32(72'(in_start_vel_x));
            vel_r[1] <= sat32(72'(in_start_vel_y));
            vel_r[2] <= sat32(72'(in_start_vel_z));
            time_r <= '0;
            state_r <= ST_DONE;
          end else if (flying) begin
            for (int i = 0; i < 3; i++)
              rel_r[i] <= sat32(72'(vel_r[i]) + (72'(wind_r[i]) <<< 8));
            sq_r <= '0;
            op_r <= '0;
            state_r <= ST_MUL;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_MUL: begin
          op_r <= op_r + 5'd1;
          unique case (op_r)
            5'd0, 5'd1, 5'd2: sq_r <= sq_r + prod[65:0];
            5'd3: acc_r[0] <= 72'(prod);
            5'd4: acc_r[0] <= acc_r[0] - 72'(prod);
            5'd5: acc_r[1] <= 72'(prod);
            5'd6: acc_r[1] <= acc_r[1] - 72'(prod);
            5'd7: acc_r[2] <= 72'(prod);
            5'd8: begin
              acc_r[2] <= acc_r[2] - 72'(prod);
              state_r <= ST_SQRT;
            end
            5'd9: k_r <= (kfull > 44'h7FFFFFFF) ? 32'h7FFFFFFF : kfull[31:0];
            5'd10, 5'd11, 5'd12: acc_r[ci] <= 72'(prod >>> 24);
            5'd13, 5'd14, 5'd15: acc_r[ci] <= acc_r[ci] + ((-72'(prod)) >>> 16);
            5'd16: begin
              for (int i = 0; i < 3; i++)
                vel_r[i] <= sat32(72'(vel_r[i]) + acc_r[i]
                                  + ((i == 1) ? 72'(grav_r) : 72'sd0));
            end
            5'd17, 5'd18: pos_r[ci] <= sat32(72'(pos_r[ci]) + (72'(prod) >>> 16));
            default: begin
              pos_r[ci] <= sat32(72'(pos_r[ci]) + (72'(prod) >>> 16));
              time_r <= ((time_r + 33'(tstep_r)) > TMAX) ? TMAX
                        : time_r + 33'(tstep_r);
              state_r <= ST_DONE;
            end
          endcase
        end
        ST_SQRT: if (!sq_go_r && !srsp.busy) begin
          state_r <= ST_MUL;
        end
        ST_DONE: state_r <= ST_OUT;
        ST_OUT: if (!out_stall) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_pos_x = pos_r[0];
  assign out_pos_y = pos_r[1];
  assign out_pos_z = pos_r[2];
  assign out_vel_x = vel_r[0];
  assign out_vel_y = vel_r[1];
  assign out_vel_z = vel_r[2];
  assign out_elapsed = time_r[31:0];
  assign out_landed = !flying;
endmodule
